// ===== src/midi_file_event_encoder_defines.svh =====
// assertion macros used by the encoder controller
`ifndef MIDI_FILE_EVENT_ENCODER_DEFINES_SVH
`define MIDI_FILE_EVENT_ENCODER_DEFINES_SVH

// clocked check, off while reset is asserted
`define MFE_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check that also holds during reset
`define MFE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/mfe_pkg.sv =====
package mfe_pkg;

  typedef enum logic [2:0] {
    REQ_FILE_HDR  = 3'd0,
    REQ_TRACK_HDR = 3'd1,
    REQ_NOTE_ON   = 3'd2,
    REQ_NOTE_OFF  = 3'd3,
    REQ_TEMPO     = 3'd4,
    REQ_END_TRACK = 3'd5
  } req_kind_e;

  localparam int unsigned IdxW   = 4;   // byte index, runs up to 14 bytes
  localparam int unsigned GroupW = 3;   // vlq group count, 1 to 4

  localparam logic [7:0] ChM       = 8'h4D;
  localparam logic [7:0] ChT       = 8'h54;
  localparam logic [7:0] ChH       = 8'h68;
  localparam logic [7:0] ChD       = 8'h64;
  localparam logic [7:0] ChR       = 8'h72;
  localparam logic [7:0] ChK       = 8'h6B;
  localparam logic [7:0] NoteOnSt  = 8'h90;
  localparam logic [7:0] NoteOffSt = 8'h80;
  localparam logic [7:0] MetaSt    = 8'hFF;
  localparam logic [7:0] MetaTempo = 8'h51;
  localparam logic [7:0] MetaEot   = 8'h2F;
  localparam logic [7:0] TempoLen  = 8'h03;
  localparam logic [7:0] HdrLen    = 8'h06;

  typedef struct packed {
    logic load;   // capture the request
    logic step;   // push the next byte into the output register
  } mfe_cmd_t;

  typedef struct packed {
    logic out_free;  // output register can take a byte this cycle
    logic is_last;   // current index is the final byte of the run
    logic kind_ok;   // captured request kind emits bytes
  } mfe_stat_t;

endpackage

// ===== src/mfe_datapath.sv =====
module mfe_datapath
  import mfe_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [2:0]  req_type_i,
  input  logic [27:0] delta_time_i,
  input  logic [3:0]  channel_i,
  input  logic [6:0]  note_i,
  input  logic [6:0]  velocity_i,
  input  logic [23:0] tempo_us_i,
  input  logic [15:0] format_type_i,
  input  logic [15:0] track_count_i,
  input  logic [15:0] ticks_per_quarter_i,
  input  logic [31:0] track_bytes_i,
  input  mfe_cmd_t    cmd_i,
  output mfe_stat_t   stat_o,
  input  logic        out_ready_i,
  output logic        out_valid_o,
  output logic [7:0]  out_byte_o,
  output logic        last_byte_o
);

  logic [2:0]        kind_q;
  logic [27:0]       delta_q;
  logic [3:0]        chan_q;
  logic [6:0]        note_q;
  logic [6:0]        vel_q;
  logic [23:0]       tempo_q;
  logic [15:0]       fmt_q;
  logic [15:0]       trk_q;
  logic [15:0]       div_q;
  logic [31:0]       len_q;
  logic [GroupW-1:0] groups_q;
  logic [IdxW-1:0]   last_idx_q;
  logic              kind_ok_q;
  logic [IdxW-1:0]   idx_q;

  logic              out_valid_q, out_valid_d;
  logic [7:0]        out_byte_q;
  logic              out_last_q;

  logic [GroupW-1:0] groups_d;
  logic [IdxW-1:0]   last_idx_d;
  logic [IdxW-1:0]   ev_idx;
  logic [1:0]        grp_sel;
  logic [6:0]        grp_bits;
  logic [7:0]        ev_byte;
  logic [7:0]        cur_byte;

  // number of 7-bit groups in the delta time
  always_comb begin
    if (delta_time_i[27:21] != 7'd0) begin
      groups_d = GroupW'(4);
    end else if (delta_time_i[20:14] != 7'd0) begin
      groups_d = GroupW'(3);
    end else if (delta_time_i[13:7] != 7'd0) begin
      groups_d = GroupW'(2);
    end else begin
      groups_d = GroupW'(1);
    end
  end

  // index of the final byte of the run
  always_comb begin
    case (req_type_i)
      REQ_FILE_HDR:  last_idx_d = IdxW'(13);
      REQ_TRACK_HDR: last_idx_d = IdxW'(7);
      REQ_TEMPO:     last_idx_d = IdxW'(groups_d) + IdxW'(5);
      default:       last_idx_d = IdxW'(groups_d) + IdxW'(2);
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q     <= req_type_i;
      delta_q    <= delta_time_i;
      chan_q     <= channel_i;
      note_q     <= note_i;
      vel_q      <= velocity_i;
      tempo_q    <= tempo_us_i;
      fmt_q      <= format_type_i;
      trk_q      <= track_count_i;
      div_q      <= ticks_per_quarter_i;
      len_q      <= track_bytes_i;
      groups_q   <= groups_d;
      last_idx_q <= last_idx_d;
      kind_ok_q  <= (req_type_i <= REQ_END_TRACK);
      idx_q      <= '0;
    end else if (cmd_i.step) begin
      idx_q      <= idx_q + IdxW'(1);
    end
    if (cmd_i.step) begin
      out_byte_q <= cur_byte;
      out_last_q <= (idx_q == last_idx_q);
    end
  end

  // vlq group, most significant first, continuation bit on all but the last
  assign grp_sel = 2'(groups_q - GroupW'(1) - idx_q[GroupW-1:0]);

  always_comb begin
    case (grp_sel)
      2'd3:    grp_bits = delta_q[27:21];
      2'd2:    grp_bits = delta_q[20:14];
      2'd1:    grp_bits = delta_q[13:7];
      default: grp_bits = delta_q[6:0];
    endcase
  end

  assign ev_idx = idx_q - IdxW'(groups_q);

  // bytes after the delta time of an event
  always_comb begin
    ev_byte = 8'h00;
    case (kind_q)
      REQ_NOTE_ON, REQ_NOTE_OFF: begin
        case (ev_idx)
          IdxW'(0): ev_byte = ((kind_q == REQ_NOTE_ON) ? NoteOnSt : NoteOffSt) | {4'h0, chan_q};
          IdxW'(1): ev_byte = {1'b0, note_q};
          default:  ev_byte = {1'b0, vel_q};
        endcase
      end
      REQ_TEMPO: begin
        case (ev_idx)
          IdxW'(0): ev_byte = MetaSt;
          IdxW'(1): ev_byte = MetaTempo;
          IdxW'(2): ev_byte = TempoLen;
          IdxW'(3): ev_byte = tempo_q[23:16];
          IdxW'(4): ev_byte = tempo_q[15:8];
          default:  ev_byte = tempo_q[7:0];
        endcase
      end
      default: begin
        case (ev_idx)
          IdxW'(0): ev_byte = MetaSt;
          IdxW'(1): ev_byte = MetaEot;
          default:  ev_byte = 8'h00;
        endcase
      end
    endcase
  end

  always_comb begin
    cur_byte = 8'h00;
    case (kind_q)
      REQ_FILE_HDR: begin
        case (idx_q)
          IdxW'(0):  cur_byte = ChM;
          IdxW'(1):  cur_byte = ChT;
          IdxW'(2):  cur_byte = ChH;
          IdxW'(3):  cur_byte = ChD;
          IdxW'(7):  cur_byte = HdrLen;
          IdxW'(8):  cur_byte = fmt_q[15:8];
          IdxW'(9):  cur_byte = fmt_q[7:0];
          IdxW'(10): cur_byte = trk_q[15:8];
          IdxW'(11): cur_byte = trk_q[7:0];
          IdxW'(12): cur_byte = div_q[15:8];
          IdxW'(13): cur_byte = div_q[7:0];
          default:   cur_byte = 8'h00;
        endcase
      end
      REQ_TRACK_HDR: begin
        case (idx_q)
          IdxW'(0): cur_byte = ChM;
          IdxW'(1): cur_byte = ChT;
          IdxW'(2): cur_byte = ChR;
          IdxW'(3): cur_byte = ChK;
          IdxW'(4): cur_byte = len_q[31:24];
          IdxW'(5): cur_byte = len_q[23:16];
          IdxW'(6): cur_byte = len_q[15:8];
          default:  cur_byte = len_q[7:0];
        endcase
      end
      default: begin
        if (idx_q < IdxW'(groups_q)) begin
          cur_byte = {(grp_sel != 2'd0), grp_bits};
        end else begin
          cur_byte = ev_byte;
        end
      end
    endcase
  end

  always_comb begin
    if (cmd_i.step) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  assign stat_o.out_free = !out_valid_q || out_ready_i;
  assign stat_o.is_last  = (idx_q == last_idx_q);
  assign stat_o.kind_ok  = kind_ok_q;

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign last_byte_o = out_last_q;

endmodule

// ===== src/mfe_ctrl.sv =====
`include "midi_file_event_encoder_defines.svh"

module mfe_ctrl
  import mfe_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      req_valid_i,
  output logic      req_ready_o,
  input  mfe_stat_t stat_i,
  output mfe_cmd_t  cmd_o
);

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_e;

  state_e state_q;

  assign req_ready_o = (state_q == ST_IDLE);
  assign cmd_o.load  = (state_q == ST_IDLE) && req_valid_i;
  assign cmd_o.step  = (state_q == ST_RUN) && stat_i.kind_ok && stat_i.out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (req_valid_i) begin
            state_q <= ST_RUN;
          end
        end
        ST_RUN: begin
          // unknown kinds emit nothing
          if (!stat_i.kind_ok) begin
            state_q <= ST_IDLE;
          end else if (stat_i.out_free && stat_i.is_last) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  `MFE_ASSERT(a_last_frees, clk_i, rst_ni, (cmd_o.step && stat_i.is_last) |=> req_ready_o, "not idle after final byte")
  `MFE_ASSERT(a_load_busy, clk_i, rst_ni, cmd_o.load |=> !req_ready_o, "request accepted but block not busy")
  `MFE_ASSERT_ALWAYS(a_step_free, clk_i, cmd_o.step |-> stat_i.out_free, "byte pushed into full output register")

endmodule

// ===== src/midi_file_event_encoder.sv =====
// channel  handshake                   payload
// req      req_valid_i / req_ready_o   req_type_i .. track_bytes_i
// out      out_valid_o / out_ready_i   out_byte_o, last_byte_o
//
// a request is captured, then the byte index counter walks the run one byte a cycle
// while the output register is free; a run is 4 to 14 bytes long
// unknown request kinds are taken, enter the run state and drop out with no bytes
// rst_ni is asynchronous, active low; it empties the output register and idles
// a stalled output holds the byte counter; the next request is taken while
// the final byte of the previous run still waits in the output register
module midi_file_event_encoder
  import mfe_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        req_valid_i,
  output logic        req_ready_o,
  input  logic [2:0]  req_type_i,
  input  logic [27:0] delta_time_i,
  input  logic [3:0]  channel_i,
  input  logic [6:0]  note_i,
  input  logic [6:0]  velocity_i,
  input  logic [23:0] tempo_us_i,
  input  logic [15:0] format_type_i,
  input  logic [15:0] track_count_i,
  input  logic [15:0] ticks_per_quarter_i,
  input  logic [31:0] track_bytes_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  out_byte_o,
  output logic        last_byte_o
);

  // command and status between sequencer and byte datapath
  mfe_cmd_t  cmd;
  mfe_stat_t stat;

  // sequencer: idle, then one byte per free output slot
  mfe_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_valid_i),
    .req_ready_o (req_ready_o),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // request capture, vlq split, byte select and output register
  mfe_datapath u_datapath (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .req_type_i          (req_type_i),
    .delta_time_i        (delta_time_i),
    .channel_i           (channel_i),
    .note_i              (note_i),
    .velocity_i          (velocity_i),
    .tempo_us_i          (tempo_us_i),
    .format_type_i       (format_type_i),
    .track_count_i       (track_count_i),
    .ticks_per_quarter_i (ticks_per_quarter_i),
    .track_bytes_i       (track_bytes_i),
    .cmd_i               (cmd),
    .stat_o              (stat),
    .out_ready_i         (out_ready_i),
    .out_valid_o         (out_valid_o),
    .out_byte_o          (out_byte_o),
    .last_byte_o         (last_byte_o)
  );

endmodule

// ===== dv/midi_file_event_encoder_tb.sv =====
`timescale 1ns / 100ps

module midi_file_event_encoder_tb;
  import mfe_pkg::*;

  // request kinds that the block takes but turns into no bytes
  localparam logic [2:0] ReqSpare6 = 3'd6;
  localparam logic [2:0] ReqSpare7 = 3'd7;

  localparam int unsigned EventGoal     = 200;     // random requests that emit bytes
  localparam int unsigned TailCycles    = 32;      // settle time after the last byte
  localparam int unsigned TimeoutCycles = 600000;  // worst case is well under this

  // one request as it sits on the request port
  typedef struct packed {
    logic [2:0]  kind;
    logic [27:0] delta;
    logic [3:0]  channel;
    logic [6:0]  note;
    logic [6:0]  velocity;
    logic [23:0] tempo;
    logic [15:0] format;
    logic [15:0] tracks;
    logic [15:0] division;
    logic [31:0] length;
  } midi_req_t;

  // byte run predictor and checker of the serialized stream
  class smf_byte_checker;
    logic [8:0]  pending_bytes[$];  // {last, byte}, oldest first
    logic [7:0]  run_bytes[14];
    int          run_len;
    int          errors;
    int          bytes_checked;
    int          runs_checked;
    int          kind_seen[8];

    function void put(logic [7:0] value);
      run_bytes[run_len] = value;
      run_len++;
    endfunction

    // delta time as a variable-length quantity, at most four groups
    function void put_delta(logic [27:0] delta);
      int          groups;
      logic [27:0] rest;
      groups = 1;
      rest   = delta >> 7;
      while (rest != 0 && groups < 4) begin
        groups++;
        rest = rest >> 7;
      end
      for (int g = groups - 1; g >= 0; g--) begin
        put({g != 0, delta[7*g +: 7]});
      end
    endfunction

    function void note_request(midi_req_t r);
      run_len = 0;
      kind_seen[r.kind]++;
      case (r.kind)
        REQ_FILE_HDR: begin
          put(ChM); put(ChT); put(ChH); put(ChD);
          put(8'h00); put(8'h00); put(8'h00); put(HdrLen);
          put(r.format[15:8]);   put(r.format[7:0]);
          put(r.tracks[15:8]);   put(r.tracks[7:0]);
          put(r.division[15:8]); put(r.division[7:0]);
        end
        REQ_TRACK_HDR: begin
          put(ChM); put(ChT); put(ChR); put(ChK);
          put(r.length[31:24]); put(r.length[23:16]);
          put(r.length[15:8]);  put(r.length[7:0]);
        end
        REQ_NOTE_ON, REQ_NOTE_OFF: begin
          put_delta(r.delta);
          put(((r.kind == REQ_NOTE_ON) ? NoteOnSt : NoteOffSt) | {4'h0, r.channel});
          put({1'b0, r.note});
          put({1'b0, r.velocity});
        end
        REQ_TEMPO: begin
          put_delta(r.delta);
          put(MetaSt); put(MetaTempo); put(TempoLen);
          put(r.tempo[23:16]); put(r.tempo[15:8]); put(r.tempo[7:0]);
        end
        REQ_END_TRACK: begin
          put_delta(r.delta);
          put(MetaSt); put(MetaEot); put(8'h00);
        end
        default: ;  // spare kinds emit nothing
      endcase
      for (int i = 0; i < run_len; i++) begin
        pending_bytes.push_back({i == run_len - 1, run_bytes[i]});
      end
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      errors++;
    endtask

    task check_byte(logic [7:0] value, logic last);
      logic [8:0] want;
      if (pending_bytes.size() == 0) begin
        report($sformatf("byte %02h (last %b) with nothing pending", value, last));
      end else begin
        want = pending_bytes.pop_front();
        bytes_checked++;
        if (want[8]) runs_checked++;
        if (value !== want[7:0])
          report($sformatf("out_byte %02h, want %02h", value, want[7:0]));
        if (last !== want[8])
          report($sformatf("last_byte %b on %02h, want %b", last, want[7:0], want[8]));
      end
    endtask

    function int pending();
      return pending_bytes.size();
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        req_valid_i = 1'b0;
  logic        req_ready_o;
  logic [2:0]  req_type_i = '0;
  logic [27:0] delta_time_i = '0;
  logic [3:0]  channel_i = '0;
  logic [6:0]  note_i = '0;
  logic [6:0]  velocity_i = '0;
  logic [23:0] tempo_us_i = '0;
  logic [15:0] format_type_i = '0;
  logic [15:0] track_count_i = '0;
  logic [15:0] ticks_per_quarter_i = '0;
  logic [31:0] track_bytes_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [7:0]  out_byte_o;
  logic        last_byte_o;

  smf_byte_checker sb;

  int          burst_left = 0;   // requests left in the current sender burst
  int          event_items = 0;  // random requests that emit bytes
  int          cycle_count = 0;
  logic [15:0] stall_pattern = 16'hFFFF;
  logic [3:0]  stall_phase = '0;

  midi_file_event_encoder i_dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // run watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == TimeoutCycles) begin
      $display("timeout after %0d cycles, %0d bytes pending", cycle_count, sb.pending());
      $display("Regression FAIL");
      $finish;
    end
  end

  // receiver: a new 16-bit ready pattern each round, from wide open to mostly stalled
  always @(posedge clk_i) begin
    if (stall_phase == 4'd15) begin
      case ($urandom_range(3))
        0:       stall_pattern <= 16'hFFFF;
        1:       stall_pattern <= 16'($urandom);
        2:       stall_pattern <= 16'($urandom | $urandom);
        default: stall_pattern <= 16'($urandom & $urandom);
      endcase
    end
    stall_phase <= stall_phase + 4'd1;
    out_ready_i <= stall_pattern[stall_phase];
  end

  // output monitor, samples the values that stood before the edge
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_byte(out_byte_o, last_byte_o);
  end

  // fixed request with every side field at zero or at all ones
  function automatic midi_req_t fixed_request(logic [2:0] kind, logic [27:0] delta,
                                              logic ones);
    midi_req_t r;
    r       = ones ? '1 : '0;
    r.kind  = kind;
    r.delta = delta;
    return r;
  endfunction

  // random fields; delta spread over one to four quantity groups
  function automatic midi_req_t random_request(logic [2:0] kind);
    midi_req_t r;
    int        span;
    span       = $urandom_range(4);
    r.kind     = kind;
    r.delta    = (span == 0) ? 28'h0 : 28'($urandom) >> (7 * (4 - span));
    if ($urandom_range(15) == 0) r.delta = '1;
    r.channel  = 4'($urandom);
    r.note     = 7'($urandom);
    r.velocity = 7'($urandom);
    r.tempo    = 24'($urandom);
    r.format   = 16'($urandom);
    r.tracks   = 16'($urandom);
    r.division = 16'($urandom);
    r.length   = $urandom;
    return r;
  endfunction

  // hold the request until it is taken, then hand it to the predictor
  task automatic send_request(midi_req_t r);
    req_valid_i         <= 1'b1;
    req_type_i          <= r.kind;
    delta_time_i        <= r.delta;
    channel_i           <= r.channel;
    note_i              <= r.note;
    velocity_i          <= r.velocity;
    tempo_us_i          <= r.tempo;
    format_type_i       <= r.format;
    track_count_i       <= r.tracks;
    ticks_per_quarter_i <= r.division;
    track_bytes_i       <= r.length;
    @(posedge clk_i);
    while (!req_ready_o) @(posedge clk_i);
    sb.note_request(r);
  endtask

  // sender pacing: bursts of back-to-back requests with idle gaps between them
  task automatic offer(midi_req_t r);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, ($urandom_range(3) == 0) ? 48 : 8);
      gap = $urandom_range(1, 10);
      req_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    burst_left--;
    send_request(r);
    if (r.kind <= REQ_END_TRACK) event_items++;
  endtask

  // sender holds off until every pending byte has come out
  task automatic drain();
    req_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // a well-formed file: header, track header, events, end of track
  task automatic play_track();
    logic [2:0] kind;
    offer(random_request(REQ_FILE_HDR));
    offer(random_request(REQ_TRACK_HDR));
    repeat ($urandom_range(3, 12)) begin
      case ($urandom_range(4))
        0, 1:    kind = REQ_NOTE_ON;
        2, 3:    kind = REQ_NOTE_OFF;
        default: kind = REQ_TEMPO;
      endcase
      offer(random_request(kind));
    end
    offer(random_request(REQ_END_TRACK));
  endtask

  initial begin
    midi_req_t r;
    logic      drained_midway;
    sb = new();
    drained_midway = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: header words at both extremes
    offer(fixed_request(REQ_FILE_HDR, 28'h0, 1'b0));
    offer(fixed_request(REQ_FILE_HDR, 28'h0, 1'b1));
    offer(fixed_request(REQ_TRACK_HDR, 28'h0, 1'b0));
    offer(fixed_request(REQ_TRACK_HDR, 28'h0, 1'b1));
    // zero delta is a single byte, full-scale delta is four
    offer(fixed_request(REQ_NOTE_ON, 28'h0, 1'b0));
    offer(fixed_request(REQ_NOTE_ON, 28'hFFF_FFFF, 1'b1));
    // each group boundary of the delta quantity
    offer(fixed_request(REQ_NOTE_OFF, 28'h000_007F, 1'b0));
    offer(fixed_request(REQ_NOTE_OFF, 28'h000_0080, 1'b1));
    offer(fixed_request(REQ_NOTE_ON, 28'h000_3FFF, 1'b1));
    offer(fixed_request(REQ_NOTE_ON, 28'h000_4000, 1'b0));
    offer(fixed_request(REQ_NOTE_OFF, 28'h01F_FFFF, 1'b0));
    offer(fixed_request(REQ_NOTE_OFF, 28'h020_0000, 1'b1));
    // tempo at both ends and the usual 120 bpm value
    offer(fixed_request(REQ_TEMPO, 28'h0, 1'b0));
    offer(fixed_request(REQ_TEMPO, 28'hFFF_FFFF, 1'b1));
    r = fixed_request(REQ_TEMPO, 28'h0000060, 1'b0);
    r.tempo = 24'd500000;
    offer(r);
    offer(fixed_request(REQ_END_TRACK, 28'h0, 1'b0));
    offer(fixed_request(REQ_END_TRACK, 28'hFFF_FFFF, 1'b1));
    // spare kinds are taken and dropped, the next request must be clean
    offer(fixed_request(ReqSpare6, 28'h0, 1'b0));
    offer(fixed_request(ReqSpare7, 28'hFFF_FFFF, 1'b1));
    offer(fixed_request(REQ_NOTE_ON, 28'h0, 1'b1));
    drain();

    // random: mostly well-formed files, some loose requests of any kind
    event_items = 0;
    while (event_items < EventGoal) begin
      if ($urandom_range(99) < 80) begin
        play_track();
      end else begin
        repeat ($urandom_range(1, 4)) offer(random_request(3'($urandom_range(7))));
      end
      if (!drained_midway && event_items >= EventGoal / 2) begin
        drain();
        drained_midway = 1'b1;
      end
    end

    // let everything pending come out, then watch for stray bytes
    req_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);

    $display("requests by kind: fhdr %0d thdr %0d on %0d off %0d tempo %0d eot %0d spare %0d",
             sb.kind_seen[0], sb.kind_seen[1], sb.kind_seen[2], sb.kind_seen[3],
             sb.kind_seen[4], sb.kind_seen[5], sb.kind_seen[6] + sb.kind_seen[7]);
    $display("checked %0d bytes in %0d runs, %0d mismatches, %0d cycles",
             sb.bytes_checked, sb.runs_checked, sb.errors, cycle_count);
    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+src
src/mfe_pkg.sv
src/mfe_datapath.sv
src/mfe_ctrl.sv
src/midi_file_event_encoder.sv
dv/midi_file_event_encoder_tb.sv
